// File: design/sfd_pkg.sv
package sfd_pkg;

	// Field widths
	localparam int unsigned TICK_W    = 7;
	localparam int unsigned NPT_W     = 12;
	localparam int unsigned TMO_W     = 20;
	localparam int unsigned LAT_W     = 19;
	localparam int unsigned STEP_W    = 17;
	localparam int unsigned FLUX_W    = 21;
	localparam int unsigned TIME_W    = 40;
	localparam int unsigned SKIP_W    = 5;
	localparam int unsigned CFG_W     = 20;

	// Configuration register indexes
	localparam logic REG_NS_PER_TICK = 1'b0;
	localparam logic REG_TIMEOUT_NS  = 1'b1;

	// Register reset values
	localparam logic [NPT_W-1:0] NS_PER_TICK_RST = 12'd1409;
	localparam logic [TMO_W-1:0] TIMEOUT_NS_RST  = 20'd1000000;

	// Classified pair handed from the front to the back
	typedef struct packed {
		logic             trk_start;
		logic             trk_end;
		logic             skip;
		logic             idx;
		logic [7:0]       data;
		logic [LAT_W-1:0] lat;
	} cmd_t;

	// One decoded interval
	typedef struct packed {
		logic [FLUX_W-1:0] flux_ns;
		logic              index_valid;
		logic [TIME_W-1:0] index_time_ns;
		logic              run_last;
	} result_t;

endpackage

// File: design/sample_pair_flux_decoder.sv
// Flux decoder for raw capture pairs (timing byte, data byte). Push one pair per
// accepted cycle while full is low; decoded flux intervals come out of a result
// queue in order, one per pop. A pair reaches the back sequencer through the
// command queue. A decoded pair occupies the back sequencer for all its data bits,
// one data bit per cycle unless stalled, before the next pair is taken; a skipped
// pair with track start or track end is consumed there without decoding, and
// other skipped pairs are dropped at the front. A pair yields up to 8 intervals;
// each is held in the back until the next interval or the pair's last data bit
// shows whether it closes the pair, so it enters the result queue with the decode
// of that next bit, and one decoded on the last bit is then released from the
// hold register. A full result queue stalls the back sequencer when a held result
// is due out. The user must write ns_per_tick (index 0) and timeout_ns (index 1)
// through the cfg port only while the block is idle; the block does not enforce it.
module sample_pair_flux_decoder #(
	parameter int unsigned SKIP_PAIRS = 16,
	parameter int unsigned CMD_DEPTH  = 4,
	parameter int unsigned RES_DEPTH  = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic                         cfg_index,
	input  logic [sfd_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         push,
	output logic                         full,
	input  logic [7:0]                   timing_byte,
	input  logic [7:0]                   data_byte,
	input  logic                         track_start,
	input  logic                         track_end,
	output logic                         empty,
	input  logic                         pop,
	output logic [sfd_pkg::FLUX_W-1:0]   flux_ns,
	output logic                         index_valid,
	output logic [sfd_pkg::TIME_W-1:0]   index_time_ns,
	output logic                         run_last
);

	import sfd_pkg::*;

	logic [NPT_W-1:0] ns_per_tick_q;
	logic [TMO_W-1:0] timeout_ns_q;
	logic             cmd_push;
	logic             cmd_full;
	logic             cmd_empty;
	logic             cmd_pop;
	cmd_t             cmd_in;
	cmd_t             cmd_head;
	logic             res_push;
	logic             res_full;
	result_t          res_in;
	result_t          res_head;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ns_per_tick_q <= NS_PER_TICK_RST;
			timeout_ns_q  <= TIMEOUT_NS_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_NS_PER_TICK: ns_per_tick_q <= cfg_data[NPT_W-1:0];
				REG_TIMEOUT_NS:  timeout_ns_q  <= cfg_data[TMO_W-1:0];
				default:         ns_per_tick_q <= ns_per_tick_q;
			endcase
		end
	end

	sfd_front #(
		.SKIP_PAIRS (SKIP_PAIRS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.timing_byte (timing_byte),
		.data_byte   (data_byte),
		.track_start (track_start),
		.track_end   (track_end),
		.ns_per_tick (ns_per_tick_q),
		.full        (full),
		.cmd_full    (cmd_full),
		.cmd_push    (cmd_push),
		.cmd         (cmd_in)
	);

	sfd_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.empty  (cmd_empty)
	);

	sfd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.timeout_ns (timeout_ns_q),
		.cmd_empty  (cmd_empty),
		.cmd        (cmd_head),
		.cmd_pop    (cmd_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res_in)
	);

	sfd_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_head),
		.empty  (empty)
	);

	assign flux_ns       = res_head.flux_ns;
	assign index_valid   = res_head.index_valid;
	assign index_time_ns = res_head.index_time_ns;
	assign run_last      = res_head.run_last;

endmodule

// File: design/sfd_fifo.sv
module sfd_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Store item
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/sfd_front.sv
module sfd_front #(
	parameter int unsigned SKIP_PAIRS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [7:0]                  timing_byte,
	input  logic [7:0]                  data_byte,
	input  logic                        track_start,
	input  logic                        track_end,
	input  logic [sfd_pkg::NPT_W-1:0]   ns_per_tick,
	output logic                        full,
	input  logic                        cmd_full,
	output logic                        cmd_push,
	output sfd_pkg::cmd_t               cmd
);

	import sfd_pkg::*;

	logic [SKIP_W-1:0] skip_count_q;
	logic              skipping_q;
	logic [SKIP_W-1:0] sc;
	logic              sz;
	logic              skip;
	logic              accept;

	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	// Track start reloads the skip window before this pair is judged
	assign sc   = track_start ? SKIP_W'(SKIP_PAIRS) : skip_count_q;
	assign sz   = track_start | skipping_q;
	assign skip = (sc != '0) || (sz && (data_byte == 8'h00));

	// Forward pairs that decode or that touch back state
	assign cmd_push = accept && (!skip || track_start || track_end);

	always_comb begin
		cmd.trk_start = track_start;
		cmd.trk_end   = track_end;
		cmd.skip      = skip;
		cmd.idx       = timing_byte[7];
		cmd.data      = data_byte;
		cmd.lat       = LAT_W'(timing_byte[TICK_W-1:0]) * LAT_W'(ns_per_tick);
	end

	// Update skip window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_count_q <= '0;
			skipping_q   <= 1'b0;
		end else if (accept) begin
			if (sc != '0) begin
				skip_count_q <= sc - 1'b1;
				skipping_q   <= sz;
			end else begin
				skip_count_q <= '0;
				skipping_q   <= sz && (data_byte == 8'h00);
			end
		end
	end

endmodule

// File: design/sfd_back.sv
module sfd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [sfd_pkg::TMO_W-1:0]   timeout_ns,
	input  logic                        cmd_empty,
	input  sfd_pkg::cmd_t               cmd,
	output logic                        cmd_pop,
	input  logic                        res_full,
	output logic                        res_push,
	output sfd_pkg::result_t            res
);

	import sfd_pkg::*;

	localparam logic [2:0] POS_FIRST = 3'd7;
	localparam logic [2:0] POS_LAST  = 3'd0;

	// Decoder state
	logic [2:0]        pos_q;
	logic [FLUX_W-1:0] partial_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] elapsed_q;
	logic              pending_q;
	logic [TIME_W-1:0] index_time_q;

	// Held result, released once it is known whether it ends its pair
	result_t           hold_q;
	logic              hold_v_q;
	logic              hold_final_q;

	logic              first;
	logic              last;
	logic              clr;
	logic              bit_active;
	logic [FLUX_W-1:0] cur_partial;
	logic [TIME_W-1:0] cur_now;
	logic [TIME_W-1:0] cur_elapsed;
	logic              cur_pending;
	logic [STEP_W-1:0] step;
	logic [FLUX_W-1:0] pnew;
	logic [TIME_W-1:0] nnew;
	logic              idx_now;
	logic              pend_eff;
	logic [TIME_W-1:0] time_eff;
	logic              emit;
	logic              flush;
	logic              go;
	result_t           new_res;

	assign first      = (pos_q == POS_FIRST);
	assign bit_active = !cmd_empty && !cmd.skip;
	assign last       = cmd.skip || (pos_q == POS_LAST);
	assign clr        = !cmd_empty && cmd.trk_start && first;

	// Apply track start clear ahead of the first bit
	assign cur_partial = clr ? '0 : partial_q;
	assign cur_now     = clr ? '0 : now_q;
	assign cur_elapsed = clr ? '0 : elapsed_q;
	assign cur_pending = clr ? 1'b0 : pending_q;

	// One eighth of the byte time, remainder on the last bit
	assign step = STEP_W'(cmd.lat[LAT_W-1:3])
		+ ((pos_q == POS_LAST) ? STEP_W'(cmd.lat[2:0]) : '0);
	assign pnew = cur_partial + FLUX_W'(step);
	assign nnew = cur_now + TIME_W'(step);

	assign idx_now  = bit_active && first && cmd.idx;
	assign pend_eff = cur_pending | idx_now;
	assign time_eff = idx_now ? cur_now : index_time_q;

	assign emit = bit_active && (cmd.data[pos_q] || (pnew >= FLUX_W'(timeout_ns)));

	always_comb begin
		new_res.flux_ns       = pnew;
		new_res.index_valid   = pend_eff;
		new_res.index_time_ns = pend_eff ? time_eff : '0;
		new_res.run_last      = 1'b0;
	end

	// Release held item on a newer result or at the end of its pair
	assign flush = hold_v_q && (hold_final_q || emit || (!cmd_empty && last));
	assign go    = !(flush && res_full);

	assign res_push = flush && go;
	always_comb begin
		res          = hold_q;
		res.run_last = hold_final_q || !emit;
	end

	assign cmd_pop = go && !cmd_empty && last;

	// Step one data bit per cycle unless a full result queue stalls a release
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= POS_FIRST;
			partial_q    <= '0;
			now_q        <= '0;
			elapsed_q    <= '0;
			pending_q    <= 1'b0;
			index_time_q <= '0;
		end else if (go && !cmd_empty) begin
			if (cmd.skip) begin
				elapsed_q <= cur_elapsed;
				if (cmd.trk_end) begin
					now_q     <= cur_elapsed;
					partial_q <= '0;
					pending_q <= 1'b0;
				end else begin
					now_q     <= cur_now;
					partial_q <= cur_partial;
					pending_q <= cur_pending;
				end
			end else begin
				index_time_q <= time_eff;
				elapsed_q    <= emit ? nnew : cur_elapsed;
				// Drop the open interval after the last bit of a track
				if (last && cmd.trk_end) begin
					partial_q <= '0;
					pending_q <= 1'b0;
					now_q     <= emit ? nnew : cur_elapsed;
				end else if (emit) begin
					partial_q <= '0;
					pending_q <= 1'b0;
					now_q     <= nnew;
				end else begin
					partial_q <= pnew;
					pending_q <= pend_eff;
					now_q     <= nnew;
				end
				pos_q <= last ? POS_FIRST : pos_q - 1'b1;
			end
		end
	end

	// Hold newest result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q     <= 1'b0;
			hold_final_q <= 1'b0;
		end else if (go) begin
			if (emit) begin
				hold_v_q     <= 1'b1;
				hold_final_q <= last;
			end else if (flush) begin
				hold_v_q     <= 1'b0;
				hold_final_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			hold_q <= new_res;
		end
	end

	// Never write a full result queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full queue");

	// A pair in progress stays at the head of the command queue
	a_mid_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q != POS_FIRST) |-> (!cmd_empty && !cmd.skip))
		else $error("bit position advanced without a pair");

	// A held result that is not final belongs to the pair in progress
	a_hold_open: assert property (@(posedge clk) disable iff (!arst_n)
		(hold_v_q && !hold_final_q) |-> (!cmd_empty && !cmd.skip && !first))
		else $error("open held result outside a pair");

	// A result that ends its pair is released right away unless stalled
	a_final_out: assert property (@(posedge clk) disable iff (!arst_n)
		(hold_v_q && hold_final_q && !res_full) |-> res_push)
		else $error("final result not released");

endmodule
